FILE: rtl/spce_pkg.sv
// Shared types and constants for the shortest path cost engine.
// No dependencies; used by spce_front, spce_back and the top level.
package spce_pkg;

    localparam int COST_W = 22;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam int NODE_W   = 5;
    localparam int WEIGHT_W = 8;
    localparam int STOP_W   = 10;
    localparam int TPU_W    = 8;

    localparam logic [STOP_W-1:0] STOP_PENALTY_RST  = 10'd120;
    localparam logic [TPU_W-1:0]  TIME_PER_UNIT_RST = 8'd40;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_PENALTY  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_PER_UNIT = 4'd1;

    // input kind codes
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // classified operations
    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_REMOVE  = 3'd1;
    localparam logic [2:0] OP_QUERY   = 3'd2;
    localparam logic [2:0] OP_IGNORE  = 3'd3;
    localparam logic [2:0] OP_NOROUTE = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_UNREACH = 2'd2;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    typedef struct packed {
        logic [2:0]          op;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] weight;
        logic                time_mode;
    } cmd_t;

endpackage

FILE: rtl/shortest_path_cost_engine.sv
// Shortest path cost engine, top level: configuration registers, front, back.
// Depends on spce_pkg, spce_front and spce_back.
//
// Each item adds an edge, removes an edge, or asks for the least path cost
// between two nodes of an undirected graph; one result comes back per item.
// After reset the edge store is swept clear, one entry a cycle; items are
// stalled until the sweep ends, configuration writes are taken throughout.
// An edge add or remove reads the entry, checks it and, if it changes, writes
// both directions. A query settles one node per round, and each round sweeps
// that node's row of the edge store one entry a cycle through the relax
// pipeline; a query ends as soon as the destination settles.
// A two-entry queue takes items while the back end is busy, and the result
// register holds a finished result while the next item starts.
module shortest_path_cost_engine #(
    parameter int NODE_COUNT  = 32,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       kind,
    input  logic [spce_pkg::NODE_W-1:0]      node_a,
    input  logic [spce_pkg::NODE_W-1:0]      node_b,
    input  logic [spce_pkg::WEIGHT_W-1:0]    weight,
    input  logic                             time_mode,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic [spce_pkg::COST_W-1:0]      path_cost,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [spce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spce_pkg::STOP_W-1:0]      cfg_data
);

    logic [spce_pkg::STOP_W-1:0] stop_penalty_reg;
    logic [spce_pkg::TPU_W-1:0]  time_per_unit_reg;
    logic                        clearing;
    logic                        cmd_valid;
    logic                        cmd_pop;
    spce_pkg::cmd_t              cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_penalty_reg  <= spce_pkg::STOP_PENALTY_RST;
            time_per_unit_reg <= spce_pkg::TIME_PER_UNIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                spce_pkg::CFG_STOP_PENALTY:  stop_penalty_reg  <= cfg_data;
                spce_pkg::CFG_TIME_PER_UNIT: time_per_unit_reg <= cfg_data[spce_pkg::TPU_W-1:0];
                default:                     ;
            endcase
        end
    end

    spce_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .node_a    (node_a),
        .node_b    (node_b),
        .weight    (weight),
        .time_mode (time_mode),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    spce_back #(
        .NODE_COUNT  (NODE_COUNT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .clearing      (clearing),
        .stop_penalty  (stop_penalty_reg),
        .time_per_unit (time_per_unit_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .path_cost     (path_cost)
    );

endmodule

FILE: rtl/spce_front.sv
// Front end: classifies accepted items and queues them for the back end.
// Depends on spce_pkg.
module spce_front #(
    parameter int NODE_COUNT = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [spce_pkg::NODE_W-1:0]   node_a,
    input  logic [spce_pkg::NODE_W-1:0]   node_b,
    input  logic [spce_pkg::WEIGHT_W-1:0] weight,
    input  logic                          time_mode,
    input  logic                          clearing,
    output logic                          cmd_valid,
    output spce_pkg::cmd_t                cmd,
    input  logic                          cmd_pop
);

    localparam logic [8:0] NC9 = 9'(NODE_COUNT);

    spce_pkg::cmd_t                 new_cmd;
    spce_pkg::cmd_t                 q_mem [spce_pkg::QDEPTH];
    logic [spce_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [spce_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [spce_pkg::QPTR_W:0]      count_reg;
    logic                           nodes_ok;
    logic                           push;

    assign nodes_ok = ({4'b0000, node_a} < NC9) && ({4'b0000, node_b} < NC9);

    always_comb
    begin
        new_cmd.node_a    = node_a;
        new_cmd.node_b    = node_b;
        new_cmd.weight    = weight;
        new_cmd.time_mode = time_mode;
        case (kind)
            spce_pkg::KIND_ADD:    new_cmd.op = nodes_ok ? spce_pkg::OP_ADD : spce_pkg::OP_IGNORE;
            spce_pkg::KIND_REMOVE: new_cmd.op = nodes_ok ? spce_pkg::OP_REMOVE
                                                         : spce_pkg::OP_IGNORE;
            spce_pkg::KIND_QUERY:  new_cmd.op = nodes_ok ? spce_pkg::OP_QUERY
                                                         : spce_pkg::OP_NOROUTE;
            default:               new_cmd.op = spce_pkg::OP_IGNORE;
        endcase
    end

    assign in_stall  = clearing || (count_reg == (spce_pkg::QPTR_W+1)'(spce_pkg::QDEPTH));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !cmd_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/spce_back.sv
// Back end: edge store, edge add/remove, Dijkstra sweep and result register.
// Depends on spce_pkg; fed by spce_front.
module spce_back #(
    parameter int NODE_COUNT  = 32,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  spce_pkg::cmd_t                    cmd,
    output logic                              cmd_pop,
    output logic                              clearing,
    input  logic [spce_pkg::STOP_W-1:0]       stop_penalty,
    input  logic [spce_pkg::TPU_W-1:0]        time_per_unit,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [spce_pkg::COST_W-1:0]       path_cost
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int EDEPTH = 1 << ADDR_W;
    localparam int WB     = WEIGHT_BITS;
    localparam int PROD_W = spce_pkg::TPU_W + WB;
    localparam int EC_W   = ((PROD_W > spce_pkg::STOP_W) ? PROD_W : spce_pkg::STOP_W) + 1;
    localparam int SUM_W  = ((EC_W > spce_pkg::COST_W) ? EC_W : spce_pkg::COST_W) + 1;
    localparam int CW     = spce_pkg::COST_W;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_EREAD  = 4'd2;
    localparam logic [3:0] ST_ECHECK = 4'd3;
    localparam logic [3:0] ST_EWR2   = 4'd4;
    localparam logic [3:0] ST_QROUND = 4'd5;
    localparam logic [3:0] ST_RELAX  = 4'd6;
    localparam logic [3:0] ST_DONE   = 4'd7;

    logic [WB:0]          edge_mem [EDEPTH];
    logic [CW-1:0]        cost_mem [NODE_COUNT];

    logic [3:0]           state_reg;
    logic [ADDR_W-1:0]    clr_idx_reg;
    logic [2:0]           op_reg;
    logic [IDX_W-1:0]     a_reg;
    logic [IDX_W-1:0]     b_reg;
    logic [WB-1:0]        w_reg;
    logic                 tmode_reg;
    logic [NODE_COUNT-1:0] reached_reg;
    logic [NODE_COUNT-1:0] settled_reg;
    logic [IDX_W-1:0]     best_reg;
    logic [CW-1:0]        best_cost_reg;
    logic [IDX_W-1:0]     issue_idx_reg;
    logic                 issuing_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     min_idx_reg;
    logic [CW-1:0]        min_cost_reg;
    logic [1:0]           res_status_reg;
    logic [CW-1:0]        res_cost_reg;
    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic [CW-1:0]        out_cost_reg;

    // relax pipeline
    logic                 v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]     i1_reg, i2_reg, i3_reg;
    logic                 pres2_reg, pres3_reg;
    logic [WB-1:0]        w2_reg;
    logic [PROD_W-1:0]    prod2_reg;
    logic [CW-1:0]        old2_reg, old3_reg;
    logic [CW-1:0]        nc3_reg;

    logic [WB:0]          edge_q;
    logic [CW-1:0]        cost_q;

    logic [IDX_W-1:0]     cmd_a;
    logic [IDX_W-1:0]     cmd_b;
    logic [15:0]          cmd_w_wide;
    logic                 e_re, e_we;
    logic [ADDR_W-1:0]    e_raddr, e_waddr;
    logic [WB:0]          e_wdata;
    logic                 c_re;
    logic [EC_W-1:0]      ec;
    logic [SUM_W-1:0]     sum;
    logic [CW-1:0]        nc;
    logic                 upd;
    logic [CW-1:0]        newv;
    logic                 cand;
    logic                 better;
    logic                 hit;
    logic                 edge_write;
    logic                 relax_end;
    logic                 load_out;

    assign cmd_a      = IDX_W'(cmd.node_a);
    assign cmd_b      = IDX_W'(cmd.node_b);
    assign cmd_w_wide = {8'h00, cmd.weight};
    assign clearing   = (state_reg == ST_CLEAR);
    assign cmd_pop    = (state_reg == ST_IDLE) && cmd_valid;
    assign hit        = edge_q[WB];
    assign edge_write = ((op_reg == spce_pkg::OP_ADD) && !hit) ||
                        ((op_reg == spce_pkg::OP_REMOVE) && hit);

    // edge store ports
    always_comb
    begin
        e_re    = (state_reg == ST_EREAD) || ((state_reg == ST_RELAX) && issuing_reg);
        e_raddr = (state_reg == ST_EREAD) ? {a_reg, b_reg} : {best_reg, issue_idx_reg};
        e_we    = 1'b0;
        e_waddr = clr_idx_reg;
        e_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                e_we = 1'b1;
            end
            ST_ECHECK:
            begin
                e_we    = edge_write;
                e_waddr = {a_reg, b_reg};
                e_wdata = (op_reg == spce_pkg::OP_ADD) ? {1'b1, w_reg} : '0;
            end
            ST_EWR2:
            begin
                e_we    = 1'b1;
                e_waddr = {b_reg, a_reg};
                e_wdata = (op_reg == spce_pkg::OP_ADD) ? {1'b1, w_reg} : '0;
            end
            default:
            begin
                e_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            edge_mem[e_waddr] <= e_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_re)
        begin
            edge_q <= edge_mem[e_raddr];
        end
    end

    assign c_re = (state_reg == ST_RELAX) && issuing_reg;

    always_ff @(posedge clk)
    begin
        if (v3_reg && upd)
        begin
            cost_mem[i3_reg] <= nc3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_re)
        begin
            cost_q <= cost_mem[issue_idx_reg];
        end
    end

    // stage 2: edge cost, add, saturate
    always_comb
    begin
        ec  = tmode_reg ? (EC_W'(stop_penalty) + EC_W'(prod2_reg)) : EC_W'(w2_reg);
        sum = SUM_W'(best_cost_reg) + SUM_W'(ec);
        nc  = (sum > SUM_W'(spce_pkg::COST_MAX)) ? spce_pkg::COST_MAX : sum[CW-1:0];
    end

    // stage 3: update decision and running minimum for the next round
    always_comb
    begin
        upd    = pres3_reg && !settled_reg[i3_reg] &&
                 (!reached_reg[i3_reg] || (nc3_reg < old3_reg));
        newv   = upd ? nc3_reg : old3_reg;
        cand   = (reached_reg[i3_reg] || upd) && !settled_reg[i3_reg];
        better = v3_reg && cand && (!found_reg || (newv < min_cost_reg));
    end

    assign relax_end = !issuing_reg && !v1_reg && !v2_reg && !v3_reg;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk)
    begin
        i1_reg    <= issue_idx_reg;
        i2_reg    <= i1_reg;
        pres2_reg <= edge_q[WB];
        w2_reg    <= edge_q[WB-1:0];
        prod2_reg <= PROD_W'(time_per_unit) * PROD_W'(edge_q[WB-1:0]);
        old2_reg  <= cost_q;
        i3_reg    <= i2_reg;
        pres3_reg <= pres2_reg;
        nc3_reg   <= nc;
        old3_reg  <= old2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= c_re;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            reached_reg    <= '0;
            settled_reg    <= '0;
            issuing_reg    <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            if (v3_reg && upd)
            begin
                reached_reg[i3_reg] <= 1'b1;
            end
            if (better)
            begin
                found_reg    <= 1'b1;
                min_idx_reg  <= i3_reg;
                min_cost_reg <= newv;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == ADDR_W'(EDEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        op_reg    <= cmd.op;
                        a_reg     <= cmd_a;
                        b_reg     <= cmd_b;
                        w_reg     <= cmd_w_wide[WB-1:0];
                        tmode_reg <= cmd.time_mode;
                        case (cmd.op)
                            spce_pkg::OP_ADD, spce_pkg::OP_REMOVE:
                            begin
                                state_reg <= ST_EREAD;
                            end
                            spce_pkg::OP_QUERY:
                            begin
                                reached_reg   <= {{(NODE_COUNT-1){1'b0}}, 1'b1} << cmd_a;
                                settled_reg   <= '0;
                                best_reg      <= cmd_a;
                                best_cost_reg <= '0;
                                state_reg     <= ST_QROUND;
                            end
                            spce_pkg::OP_NOROUTE:
                            begin
                                res_status_reg <= spce_pkg::STAT_UNREACH;
                                res_cost_reg   <= spce_pkg::COST_MAX;
                                state_reg      <= ST_DONE;
                            end
                            default:
                            begin
                                res_status_reg <= spce_pkg::STAT_IGNORED;
                                res_cost_reg   <= '0;
                                state_reg      <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_EREAD:
                begin
                    state_reg <= ST_ECHECK;
                end
                ST_ECHECK:
                begin
                    res_cost_reg <= '0;
                    if (edge_write)
                    begin
                        res_status_reg <= spce_pkg::STAT_DONE;
                        state_reg      <= ST_EWR2;
                    end
                    else
                    begin
                        res_status_reg <= spce_pkg::STAT_IGNORED;
                        state_reg      <= ST_DONE;
                    end
                end
                ST_EWR2:
                begin
                    state_reg <= ST_DONE;
                end
                ST_QROUND:
                begin
                    settled_reg[best_reg] <= 1'b1;
                    if (best_reg == b_reg)
                    begin
                        res_status_reg <= spce_pkg::STAT_DONE;
                        res_cost_reg   <= best_cost_reg;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        issue_idx_reg <= '0;
                        issuing_reg   <= 1'b1;
                        found_reg     <= 1'b0;
                        state_reg     <= ST_RELAX;
                    end
                end
                ST_RELAX:
                begin
                    if (issuing_reg)
                    begin
                        if (issue_idx_reg == IDX_W'(NODE_COUNT - 1))
                        begin
                            issuing_reg <= 1'b0;
                        end
                        else
                        begin
                            issue_idx_reg <= issue_idx_reg + 1'b1;
                        end
                    end
                    else if (relax_end)
                    begin
                        if (found_reg)
                        begin
                            best_reg      <= min_idx_reg;
                            best_cost_reg <= min_cost_reg;
                            state_reg     <= ST_QROUND;
                        end
                        else
                        begin
                            res_status_reg <= spce_pkg::STAT_UNREACH;
                            res_cost_reg   <= spce_pkg::COST_MAX;
                            state_reg      <= ST_DONE;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_cost_reg   <= res_cost_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign path_cost = out_cost_reg;

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !cmd_pop)
        else $error("queue popped during edge store clear");

    a_best_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RELAX) |-> settled_reg[best_reg])
        else $error("relaxing row of an unsettled node");

    a_min_cand: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RELAX && relax_end && found_reg) |->
        (reached_reg[min_idx_reg] && !settled_reg[min_idx_reg]))
        else $error("next node is not a reached unsettled node");

    a_unreach_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == spce_pkg::STAT_UNREACH) |->
        (out_cost_reg == spce_pkg::COST_MAX))
        else $error("unreachable result without saturated cost");

endmodule

FILE: tb/sv/testbench.sv
// Testbench for shortest_path_cost_engine: edge add/remove and path queries
// checked against an in-bench Dijkstra predictor. Depends on spce_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 32;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int EXP_DEPTH = 1024;
    localparam logic [1:0] KIND_NOP = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] kind = spce_pkg::KIND_ADD;
    logic [spce_pkg::NODE_W-1:0] node_a = '0;
    logic [spce_pkg::NODE_W-1:0] node_b = '0;
    logic [spce_pkg::WEIGHT_W-1:0] weight = '0;
    logic time_mode = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic [spce_pkg::COST_W-1:0] path_cost;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [spce_pkg::CFG_IDX_W-1:0] cfg_index = spce_pkg::CFG_STOP_PENALTY;
    logic [spce_pkg::STOP_W-1:0] cfg_data = '0;

    shortest_path_cost_engine u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [spce_pkg::WEIGHT_W:0] graph_edges [NODES][NODES];
    logic [spce_pkg::STOP_W-1:0] pen_q = spce_pkg::STOP_PENALTY_RST;
    logic [spce_pkg::TPU_W-1:0] tpu_q = spce_pkg::TIME_PER_UNIT_RST;

    typedef struct packed {
        logic [1:0] st;
        logic [spce_pkg::COST_W-1:0] cost;
    } answer_t;
    answer_t exp_fifo [EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;

    int mismatches = 0;
    int results_seen = 0;
    int queries_sent = 0;
    longint cycles = 0;
    bit hold_off = 1'b0;
    bit stall_on = 1'b1;
    int burst_max = 6;

    function automatic answer_t shortest_cost(logic [spce_pkg::NODE_W-1:0] src,
                                              logic [spce_pkg::NODE_W-1:0] dst, logic tm);
        longint cost_est [NODES];
        bit reached [NODES];
        bit done [NODES];
        longint nc;
        int best;
        answer_t r;
        foreach (cost_est[i])
        begin
            cost_est[i] = 0;
            reached[i] = 0;
            done[i] = 0;
        end
        reached[src] = 1;
        r.st = spce_pkg::STAT_UNREACH;
        r.cost = spce_pkg::COST_MAX;
        for (int k = 0; k < NODES; k++)
        begin
            best = -1;
            for (int i = 0; i < NODES; i++)
                if (reached[i] && !done[i] && (best < 0 || cost_est[i] < cost_est[best]))
                    best = i;
            if (best < 0)
                break;
            done[best] = 1;
            if (best == dst)
            begin
                r.st = spce_pkg::STAT_DONE;
                r.cost = cost_est[best][spce_pkg::COST_W-1:0];
                break;
            end
            for (int i = 0; i < NODES; i++)
            begin
                if (!graph_edges[best][i][spce_pkg::WEIGHT_W] || done[i])
                    continue;
                nc = cost_est[best] + (tm ? longint'(pen_q) + longint'(tpu_q)
                     * graph_edges[best][i][spce_pkg::WEIGHT_W-1:0]
                     : longint'(graph_edges[best][i][spce_pkg::WEIGHT_W-1:0]));
                if (nc > spce_pkg::COST_MAX)
                    nc = spce_pkg::COST_MAX;
                if (!reached[i] || nc < cost_est[i])
                begin
                    cost_est[i] = nc;
                    reached[i] = 1;
                end
            end
        end
        return r;
    endfunction

    function automatic answer_t apply_item(logic [1:0] k, logic [spce_pkg::NODE_W-1:0] a,
                                           logic [spce_pkg::NODE_W-1:0] b,
                                           logic [spce_pkg::WEIGHT_W-1:0] w, logic tm);
        answer_t r;
        r.st = spce_pkg::STAT_IGNORED;
        r.cost = '0;
        if (k == spce_pkg::KIND_ADD && !graph_edges[a][b][spce_pkg::WEIGHT_W])
        begin
            graph_edges[a][b] = {1'b1, w};
            graph_edges[b][a] = {1'b1, w};
            r.st = spce_pkg::STAT_DONE;
        end
        else if (k == spce_pkg::KIND_REMOVE && graph_edges[a][b][spce_pkg::WEIGHT_W])
        begin
            graph_edges[a][b] = '0;
            graph_edges[b][a] = '0;
            r.st = spce_pkg::STAT_DONE;
        end
        else if (k == spce_pkg::KIND_QUERY)
            r = shortest_cost(a, b, tm);
        return r;
    endfunction

    task automatic send_item(logic [1:0] k, logic [spce_pkg::NODE_W-1:0] a,
                             logic [spce_pkg::NODE_W-1:0] b,
                             logic [spce_pkg::WEIGHT_W-1:0] w, logic tm);
        kind <= k;
        node_a <= a;
        node_b <= b;
        weight <= w;
        time_mode <= tm;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        exp_fifo[exp_wr % EXP_DEPTH] = apply_item(k, a, b, w, tm);
        exp_wr++;
        if (k == spce_pkg::KIND_QUERY)
            queries_sent++;
        @(negedge clk);
        // burst ends at random; gap length random
        if ($urandom_range(burst_max, 0) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(negedge clk);
        repeat (1300) @(negedge clk);
    endtask

    task automatic write_reg(logic [spce_pkg::CFG_IDX_W-1:0] idx,
                             logic [spce_pkg::STOP_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == spce_pkg::CFG_STOP_PENALTY)
            pen_q = val;
        else
            tpu_q = val[spce_pkg::TPU_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_edge_ops();
        send_item(spce_pkg::KIND_REMOVE, 5'd3, 5'd4, 8'd0, 1'b0);  // absent edge
        send_item(spce_pkg::KIND_ADD, 5'd0, 5'd31, 8'd255, 1'b0);
        send_item(spce_pkg::KIND_ADD, 5'd31, 5'd0, 8'd1, 1'b0);    // exists, reversed
        send_item(spce_pkg::KIND_ADD, 5'd7, 5'd7, 8'd9, 1'b0);     // self loop
        send_item(spce_pkg::KIND_ADD, 5'd0, 5'd1, 8'd0, 1'b0);
        send_item(spce_pkg::KIND_ADD, 5'd1, 5'd31, 8'd10, 1'b0);
        send_item(KIND_NOP, 5'd1, 5'd2, 8'd3, 1'b1);               // no-op kind
        send_item(spce_pkg::KIND_REMOVE, 5'd31, 5'd0, 8'd0, 1'b0);
    endtask

    task automatic test_queries();
        send_item(spce_pkg::KIND_QUERY, 5'd0, 5'd31, 8'd0, 1'b0);
        send_item(spce_pkg::KIND_QUERY, 5'd0, 5'd31, 8'd0, 1'b1);
        send_item(spce_pkg::KIND_QUERY, 5'd9, 5'd9, 8'd0, 1'b1);   // src equals dst
        send_item(spce_pkg::KIND_QUERY, 5'd0, 5'd20, 8'd0, 1'b0);  // unreachable
        send_item(spce_pkg::KIND_QUERY, 5'd7, 5'd7, 8'd0, 1'b0);
        send_item(spce_pkg::KIND_ADD, 5'd31, 5'd30, 8'd255, 1'b0);
        send_item(spce_pkg::KIND_QUERY, 5'd30, 5'd0, 8'd0, 1'b1);
    endtask

    task automatic test_saturation();
        drain();
        write_reg(spce_pkg::CFG_STOP_PENALTY, 10'd1023);
        write_reg(spce_pkg::CFG_TIME_PER_UNIT, 10'd255);
        // chain of heavy edges for large time-mode path costs
        for (int i = 10; i < 29; i++)
            send_item(spce_pkg::KIND_ADD, 5'(i), 5'(i + 1), 8'd255, 1'b0);
        send_item(spce_pkg::KIND_QUERY, 5'd10, 5'd29, 8'd0, 1'b1);
        send_item(spce_pkg::KIND_QUERY, 5'd29, 5'd10, 8'd0, 1'b0);
        drain();
        write_reg(spce_pkg::CFG_STOP_PENALTY, 10'd0);
        write_reg(spce_pkg::CFG_TIME_PER_UNIT, 10'd0);
        send_item(spce_pkg::KIND_QUERY, 5'd10, 5'd29, 8'd0, 1'b1);
    endtask

    task automatic test_backpressure();
        // receiver holds off long while sender keeps offering
        burst_max = 1000;
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
        join_none
        for (int i = 0; i < 6; i++)
            send_item(spce_pkg::KIND_ADD, 5'($urandom_range(31)), 5'($urandom_range(31)),
                      8'($urandom), 1'b0);
        drain();  // sender pauses until everything is back
        burst_max = 6;
    endtask

    task automatic test_random(int count);
        int r;
        logic [1:0] k;
        for (int n = 0; n < count; n++)
        begin
            if (n % 90 == 0)
            begin
                drain();
                write_reg(spce_pkg::CFG_STOP_PENALTY, 10'($urandom));
                write_reg(spce_pkg::CFG_TIME_PER_UNIT, 10'($urandom_range(255)));
                stall_on = (n % 180 == 0);
            end
            r = $urandom_range(99);
            k = (r < 45) ? spce_pkg::KIND_ADD : (r < 70) ? spce_pkg::KIND_REMOVE :
                (r < 97) ? spce_pkg::KIND_QUERY : KIND_NOP;
            // small node subset most of the time makes connected queries likely
            if ($urandom_range(3) != 0)
                send_item(k, 5'($urandom_range(11)), 5'($urandom_range(11)),
                          8'($urandom), 1'($urandom));
            else
                send_item(k, 5'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (stall_on)
            out_stall <= ($urandom_range(7) < 3);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        answer_t exp_r;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (exp_wr == exp_rd)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result status=%0d cost=%0d", status, path_cost);
            end
            else
            begin
                exp_r = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (status !== exp_r.st || path_cost !== exp_r.cost)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected status=%0d cost=%0d, got %0d %0d",
                                 exp_r.st, exp_r.cost, status, path_cost);
                end
            end
        end
    end

    initial
    begin
        foreach (graph_edges[i, j])
            graph_edges[i][j] = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_edge_ops();
        test_queries();
        test_saturation();
        test_backpressure();
        test_random(500);
        drain();
        $display("Covered %0d results, %0d of them path queries, with stalls and reg writes.",
                 results_seen, queries_sent);
        if (mismatches == 0 && exp_wr == exp_rd)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
